// File: rtl/core/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants for the Sobel edge magnitude core.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int FW_W          = 11;
    localparam int FH_W          = 12;
    localparam int FW_RESET      = 640;
    localparam int FH_RESET      = 480;
    localparam int PIX_W         = 24;
    localparam int CH_W          = 8;
    localparam int GRAD_W        = 10;
    localparam int SUM_W         = 21;
    localparam int SAT_LIMIT     = 65280;
    localparam int MAG_MAX       = 255;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 12;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_edge;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

endpackage

// File: rtl/core/sobel_edge_magnitude_core.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_core
// 3x3 Sobel edge magnitude per RGB channel on a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order; each output pixel leaves one row and one pixel
// behind its input, so W+1 flush beats (tuser high) after a frame push out its
// last row, and tlast marks the frame's final output. A pixel that produces no
// output passes through accept, then line store read data and write-back. A
// pixel that produces an output passes through accept, write-back, the two
// gradient stages, the radix-4 square root (eight steps and the done flag; one
// per channel, run in parallel), and the output load. The output load waits
// while the previous beat is still stalled in the output register; the next
// input is accepted while a finished output waits there. Configuration writes
// are taken only between items, ahead of a pending input beat. No clearing
// pass follows reset; line store contents are not needed until written.
module sobel_edge_magnitude_core #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,  // red, green, blue
    input  logic                           s_axis_tuser,  // action (1 = flush)
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [23:0]                    m_axis_tdata,  // red, green, blue
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sem_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WW > FW_W) ? WW : FW_W;
    localparam int RW = FH_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_GRAD,
        S_ROOT,
        S_OUT
    } t_state;

    t_state          r_state;
    logic [FW_W-1:0] r_fw;
    logic [FH_W-1:0] r_fh;
    logic [AW-1:0]   r_icol;
    logic [FH_W-1:0] r_irow;
    logic [AW-1:0]   r_ocol;
    logic [FH_W-1:0] r_orow;
    t_rgb            r_pix;
    t_rgb            r_win [3][3];
    t_edge           r_edge;
    logic            r_last;
    logic            r_grad_go;
    logic            r_out_valid;
    t_rgb            r_out;
    logic            r_out_last;

    logic [CW-1:0]    fw_ext;
    logic [CW-1:0]    w_eff;
    logic [RW-1:0]    h_eff;
    logic [CW-1:0]    icol_nx;
    logic [CW-1:0]    ocol_nx;
    logic [RW-1:0]    orow_nx;
    logic             icol_wrap;
    logic             ocol_wrap;
    logic             orow_end;
    logic             emit;
    logic             in_beat;
    logic             out_free;
    logic             out_load;
    t_rgb             up_rd;
    t_rgb             mid_rd;
    logic             grad_done;
    logic [SUM_W-1:0] grad_sum [3];
    logic [2:0]       root_done;
    logic [CH_W-1:0]  mag [3];

    assign fw_ext  = CW'(r_fw);
    assign w_eff   = (r_fw == '0) ? CW'(1)
                   : (fw_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : fw_ext;
    assign h_eff   = (r_fh == '0) ? RW'(1) : RW'(r_fh);
    assign icol_nx = CW'(r_icol) + CW'(1);
    assign ocol_nx = CW'(r_ocol) + CW'(1);
    assign orow_nx = RW'(r_orow) + RW'(1);
    assign icol_wrap = icol_nx >= w_eff;
    assign ocol_wrap = ocol_nx >= w_eff;
    assign orow_end  = orow_nx >= h_eff;
    assign emit = (r_irow >= FH_W'(2)) || ((r_irow == FH_W'(1)) && (r_icol != '0));

    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign out_load      = (r_state == S_OUT) && out_free;
    assign o_cfg_ready   = (r_state == S_IDLE);

    sem_line_mem #(.DEPTH(MAX_WIDTH)) u_upper (
        .i_clk     (i_clk),
        .i_rd_en   (in_beat),
        .i_rd_addr (r_icol),
        .o_rd_data (up_rd),
        .i_wr_en   (r_state == S_READ),
        .i_wr_addr (r_icol),
        .i_wr_data (mid_rd)
    );

    sem_line_mem #(.DEPTH(MAX_WIDTH)) u_middle (
        .i_clk     (i_clk),
        .i_rd_en   (in_beat),
        .i_rd_addr (r_icol),
        .o_rd_data (mid_rd),
        .i_wr_en   (r_state == S_READ),
        .i_wr_addr (r_icol),
        .i_wr_data (r_pix)
    );

    sem_grad u_grad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_grad_go),
        .i_win   (r_win),
        .i_edge  (r_edge),
        .o_done  (grad_done),
        .o_sum   (grad_sum)
    );

    for (genvar c = 0; c < 3; c++) begin : g_root
        sem_root u_root (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (grad_done),
            .i_sum   (grad_sum[c]),
            .o_done  (root_done[c]),
            .o_mag   (mag[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fw        <= FW_W'(FW_RESET);
            r_fh        <= FH_W'(FH_RESET);
            r_icol      <= '0;
            r_irow      <= '0;
            r_ocol      <= '0;
            r_orow      <= '0;
            r_grad_go   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_FRAME_WIDTH:  r_fw <= i_cfg_data[FW_W-1:0];
                    CFG_FRAME_HEIGHT: r_fh <= i_cfg_data[FH_W-1:0];
                endcase
            end
            r_grad_go <= (r_state == S_READ) && emit;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_pix   <= s_axis_tuser ? '0 : t_rgb'{red:   s_axis_tdata[7:0],
                                                              green: s_axis_tdata[15:8],
                                                              blue:  s_axis_tdata[23:16]};
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    for (int i = 0; i < 3; i++) begin
                        r_win[i][0] <= r_win[i][1];
                        r_win[i][1] <= r_win[i][2];
                    end
                    r_win[0][2] <= up_rd;
                    r_win[1][2] <= mid_rd;
                    r_win[2][2] <= r_pix;
                    if (icol_wrap) begin
                        r_icol <= '0;
                        r_irow <= r_irow + FH_W'(1);
                    end else begin
                        r_icol <= r_icol + AW'(1);
                    end
                    r_edge <= '{top:    r_orow != '0,
                                bottom: !orow_end,
                                left:   r_ocol != '0,
                                right:  !ocol_wrap};
                    r_last <= orow_end && ocol_wrap;
                    if (emit) begin
                        r_state <= S_GRAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_GRAD: begin
                    if (grad_done) begin
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (&root_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out       <= '{red: mag[0], green: mag[1], blue: mag[2]};
                        r_out_last  <= r_last;
                        if (r_last) begin
                            r_icol <= '0;
                            r_irow <= '0;
                            r_ocol <= '0;
                            r_orow <= '0;
                        end else if (ocol_wrap) begin
                            r_ocol <= '0;
                            r_orow <= r_orow + FH_W'(1);
                        end else begin
                            r_ocol <= r_ocol + AW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.blue, r_out.green, r_out.red};
    assign m_axis_tlast  = r_out_last;

endmodule

// File: rtl/core/sem_line_mem.sv
// ----------------------------------------------------------------------------
// sem_line_mem
// One line store: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sem_line_mem #(
    parameter  int DEPTH = sem_pkg::MAX_WIDTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output sem_pkg::t_rgb o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  sem_pkg::t_rgb i_wr_data
);
    import sem_pkg::*;

    t_rgb r_mem [DEPTH];
    t_rgb r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/sem_grad.sv
// ----------------------------------------------------------------------------
// sem_grad
// Masked Sobel Gx/Gy per channel, then sum of squares. Two register stages.
// ----------------------------------------------------------------------------
module sem_grad (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  sem_pkg::t_rgb             i_win [3][3],
    input  sem_pkg::t_edge            i_edge,
    output logic                      o_done,
    output logic [sem_pkg::SUM_W-1:0] o_sum [3]
);
    import sem_pkg::*;

    localparam int GS_W = GRAD_W + 2;
    localparam int SQ_W = 2 * GRAD_W;

    logic signed [GS_W-1:0] v  [3][3][3];
    logic signed [GS_W-1:0] gx [3];
    logic signed [GS_W-1:0] gy [3];
    logic [GRAD_W-1:0]      ax [3];
    logic [GRAD_W-1:0]      ay [3];
    logic [GRAD_W-1:0]      r_ax [3];
    logic [GRAD_W-1:0]      r_ay [3];
    logic [SUM_W-1:0]       r_sum [3];
    logic [SQ_W-1:0]        sq_x [3];
    logic [SQ_W-1:0]        sq_y [3];
    logic                   r_v1;
    logic                   r_v2;

    function automatic logic [CH_W-1:0] chan(input t_rgb p, input int c);
        logic [CH_W-1:0] res;
        case (c)
            0:       res = p.red;
            1:       res = p.green;
            default: res = p.blue;
        endcase
        return res;
    endfunction

    always_comb begin
        logic rv;
        logic cv;
        for (int c = 0; c < 3; c++) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    rv = (i == 0) ? i_edge.top  : (i == 2) ? i_edge.bottom : 1'b1;
                    cv = (j == 0) ? i_edge.left : (j == 2) ? i_edge.right  : 1'b1;
                    v[c][i][j] = (rv && cv) ? $signed(GS_W'(chan(i_win[i][j], c))) : '0;
                end
            end
            gx[c] = (v[c][0][2] - v[c][0][0]) + ((v[c][1][2] - v[c][1][0]) <<< 1)
                  + (v[c][2][2] - v[c][2][0]);
            gy[c] = (v[c][2][0] - v[c][0][0]) + ((v[c][2][1] - v[c][0][1]) <<< 1)
                  + (v[c][2][2] - v[c][0][2]);
            ax[c] = gx[c][GS_W-1] ? GRAD_W'(-gx[c]) : GRAD_W'(gx[c]);
            ay[c] = gy[c][GS_W-1] ? GRAD_W'(-gy[c]) : GRAD_W'(gy[c]);
            sq_x[c] = SQ_W'(r_ax[c]) * SQ_W'(r_ax[c]);
            sq_y[c] = SQ_W'(r_ay[c]) * SQ_W'(r_ay[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
        for (int c = 0; c < 3; c++) begin
            if (i_start) begin
                r_ax[c] <= ax[c];
                r_ay[c] <= ay[c];
            end
            if (r_v1) begin
                r_sum[c] <= SUM_W'(sq_x[c]) + SUM_W'(sq_y[c]);
            end
        end
    end

    assign o_done = r_v2;
    assign o_sum  = r_sum;

endmodule

// File: rtl/core/sem_root.sv
// ----------------------------------------------------------------------------
// sem_root
// Rounded integer square root, saturated at 255. Two radicand bits per cycle.
// ----------------------------------------------------------------------------
module sem_root (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sem_pkg::SUM_W-1:0] i_sum,
    output logic                      o_done,
    output logic [sem_pkg::CH_W-1:0]  o_mag
);
    import sem_pkg::*;

    localparam int STEPS = CH_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam int REM_W = CH_W + 2;
    localparam int SH_W  = REM_W + 2;
    localparam int RAD_W = 2 * CH_W;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [REM_W-1:0] r_rem;
    logic [CH_W-1:0]  r_root;
    logic [RAD_W-1:0] r_bits;
    logic             r_sat;
    logic [SH_W-1:0]  rem_sh;
    logic [SH_W-1:0]  trial;
    logic [SH_W-1:0]  rem_sub;
    logic             take;

    assign rem_sh  = {r_rem, r_bits[RAD_W-1 -: 2]};
    assign trial   = {2'b00, r_root, 2'b01};
    assign take    = rem_sh >= trial;
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_root <= '0;
                r_bits <= i_sum[RAD_W-1:0];
                r_sat  <= i_sum > SUM_W'(SAT_LIMIT);
            end else if (r_busy) begin
                r_rem  <= take ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
                r_root <= {r_root[CH_W-2:0], take};
                r_bits <= {r_bits[RAD_W-3:0], 2'b00};
                r_cnt  <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder above root means the fraction is past one half
    assign o_mag  = r_sat ? CH_W'(MAG_MAX)
                  : (REM_W'(r_root) < r_rem) ? r_root + CH_W'(1) : r_root;
    assign o_done = r_done;

endmodule

// File: rtl/core/sem_port_checker.sv
// ----------------------------------------------------------------------------
// sem_port_checker
// Port-level checks on the Sobel edge magnitude core, bound to the top level.
// ----------------------------------------------------------------------------
module sem_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // one item in flight: no input beat right after another
    a_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on back-to-back cycles");

    // an output needs line store read and the root pass; never the cycle after input
    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("output appeared right after an input beat");

    // input side idles while a new output is being produced
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("input ready during output load");

endmodule

bind sobel_edge_magnitude_core sem_port_checker u_sem_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
